// File: src/utf8_label_validator_macros.svh
// assertion macros shared by the checker of the utf8 label validator
// expects signals named clk and arst_n in the scope of each use
`ifndef UTF8_LABEL_VALIDATOR_MACROS_SVH
`define UTF8_LABEL_VALIDATOR_MACROS_SVH

// same-cycle implication, disabled during reset
`define ULV_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define ULV_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: src/ulv_pkg.sv
// types, constants and helpers of the utf8 label validator
// no dependencies
`default_nettype none

package ulv_pkg;

	// lead byte ranges
	localparam logic [7:0] ASCII_LIMIT = 8'h80;
	localparam logic [7:0] LEAD2_LO    = 8'hC2;
	localparam logic [7:0] LEAD2_HI    = 8'hDF;
	localparam logic [7:0] LEAD3_LO    = 8'hE0;
	localparam logic [7:0] LEAD3_HI    = 8'hEF;
	localparam logic [7:0] LEAD4_LO    = 8'hF0;
	localparam logic [7:0] LEAD4_HI    = 8'hF4;

	// continuation byte tag in the top two bits
	localparam logic [1:0] CONT_TAG = 2'b10;

	// code point limits
	localparam logic [20:0] CODE_MAX  = 21'h10FFFF;
	localparam logic [20:0] SURR_LO   = 21'h00D800;
	localparam logic [20:0] SURR_HI   = 21'h00DFFF;
	localparam logic [20:0] MIN_TWO   = 21'h000080;
	localparam logic [20:0] MIN_THREE = 21'h000800;
	localparam logic [20:0] MIN_FOUR  = 21'h010000;

	// sequence classes
	localparam logic [1:0] CLS_NONE  = 2'd0;
	localparam logic [1:0] CLS_TWO   = 2'd1;
	localparam logic [1:0] CLS_THREE = 2'd2;
	localparam logic [1:0] CLS_FOUR  = 2'd3;

	typedef struct packed {
		logic [7:0]  bytes_left;
		logic [7:0]  record_length;
		logic [1:0]  cont_needed;
		logic [1:0]  lead_class;
		logic [20:0] partial_code;
		logic        bad_seen;
	} ulv_state_t;

	typedef struct packed {
		logic       valid;
		logic       ok;
		logic [7:0] length;
	} ulv_result_t;

	// smallest code point that a class may encode
	function automatic logic [20:0] class_minimum(input logic [1:0] cls);
		logic [20:0] m;
		case (cls)
			CLS_TWO:   m = MIN_TWO;
			CLS_THREE: m = MIN_THREE;
			default:   m = MIN_FOUR;
		endcase
		return m;
	endfunction

	// unicode scalar value: in range and not a surrogate
	function automatic logic is_scalar(input logic [20:0] v);
		return (v <= CODE_MAX) && !((v >= SURR_LO) && (v <= SURR_HI));
	endfunction

endpackage

`default_nettype wire

// File: src/ulv_decode.sv
// per-byte next-state and verdict logic of the utf8 label validator
// depends on ulv_pkg
`default_nettype none

module ulv_decode import ulv_pkg::*; (
	input  var ulv_state_t  cur,
	input  wire logic [7:0] data_byte,
	output ulv_state_t      nxt,
	output ulv_result_t     res
);

	logic [7:0]  bl;
	logic        bad;
	logic [1:0]  cont;
	logic [1:0]  cls;
	logic [20:0] code;

	// one byte step of the label parser
	always_comb begin
		nxt  = cur;
		res  = '0;
		bl   = cur.bytes_left - 8'd1;
		bad  = cur.bad_seen;
		cont = cur.cont_needed;
		cls  = cur.lead_class;
		code = cur.partial_code;
		if (cur.bytes_left == '0) begin
			// length prefix
			if (data_byte == '0) begin
				res.valid  = 1'b1;
				res.ok     = 1'b0;
				res.length = '0;
			end else begin
				nxt               = '0;
				nxt.bytes_left    = data_byte;
				nxt.record_length = data_byte;
			end
		end else begin
			if (!bad) begin
				if (cont == '0) begin
					// lead byte
					if (data_byte < ASCII_LIMIT) begin
						cont = '0;
					end else if (data_byte inside {[LEAD2_LO:LEAD2_HI]}) begin
						cont = 2'd1;
						cls  = CLS_TWO;
						code = {16'b0, data_byte[4:0]};
					end else if (data_byte inside {[LEAD3_LO:LEAD3_HI]}) begin
						cont = 2'd2;
						cls  = CLS_THREE;
						code = {17'b0, data_byte[3:0]};
					end else if (data_byte inside {[LEAD4_LO:LEAD4_HI]}) begin
						cont = 2'd3;
						cls  = CLS_FOUR;
						code = {18'b0, data_byte[2:0]};
					end else begin
						bad = 1'b1;
					end
					// sequence cut off by the label end
					if (bl < {6'b0, cont}) begin
						bad = 1'b1;
					end
				end else begin
					// continuation byte
					if (data_byte[7:6] != CONT_TAG) begin
						bad = 1'b1;
					end else begin
						code = {code[14:0], data_byte[5:0]};
						cont = cont - 2'd1;
						if (cont == '0) begin
							if ((code < class_minimum(cls)) || !is_scalar(code)) begin
								bad = 1'b1;
							end
						end
					end
				end
			end
			if (bad) begin
				cont = '0;
			end
			nxt.bytes_left   = bl;
			nxt.cont_needed  = cont;
			nxt.lead_class   = cls;
			nxt.partial_code = code;
			nxt.bad_seen     = bad;
			// last byte of the label
			if (bl == '0) begin
				res.valid  = 1'b1;
				res.ok     = !bad && (cont == '0);
				res.length = cur.record_length;
				nxt        = '0;
			end
		end
	end

endmodule

`default_nettype wire

// File: src/utf8_label_validator.sv
// top level of the utf8 label validator: input register, decode, result register
// depends on ulv_pkg and ulv_decode
`default_nettype none

// Takes a stream of length-prefixed labels, one byte per beat: a length byte, then
// that many bytes of UTF-8. One verdict (label_ok, label_length) comes out after the
// last byte of each label, and at once for a zero length byte. Each byte is held in
// the input register and its decode is captured by the result register, so a verdict
// passes through both registers after its last byte is taken; the block accepts one
// byte per cycle for as long as the result register can be emptied, the single result
// register being the only point where a stalled output holds back input.
module utf8_label_validator import ulv_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] data_byte,
	output logic            out_valid,
	input  wire logic       out_ready,
	output logic            label_ok,
	output logic [7:0]      label_length
);

	logic        valid_s1;
	logic [7:0]  byte_s1;
	ulv_state_t  state_q;
	ulv_state_t  state_nxt;
	ulv_result_t res;
	logic        out_valid_q;
	logic        ok_q;
	logic [7:0]  len_q;
	logic        out_free;
	logic        advance;

	// decode of the byte held in the input register
	ulv_decode u_decode (
		.cur       (state_q),
		.data_byte (byte_s1),
		.nxt       (state_nxt),
		.res       (res)
	);

	// handshake: a byte moves on unless its verdict finds the result register full and not being emptied
	assign out_free = !out_valid_q || out_ready;
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign in_ready = !valid_s1 || advance;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			byte_s1 <= data_byte;
		end
	end

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			ok_q  <= res.ok;
			len_q <= res.length;
		end
	end

	assign out_valid    = out_valid_q;
	assign label_ok     = ok_q;
	assign label_length = len_q;

endmodule

`default_nettype wire

// File: src/ulv_checker.sv
// port-level checker of the utf8 label validator, bound to the top level
// depends on utf8_label_validator_macros.svh
`default_nettype none

`include "utf8_label_validator_macros.svh"

module ulv_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_ready,
	input wire logic       out_valid,
	input wire logic       out_ready,
	input wire logic       label_ok,
	input wire logic [7:0] label_length
);

	// input only stalls behind a full, stalled result register
	`ULV_ASSERT_NOW(a_stall_cause, !in_ready, out_valid && !out_ready, "input stalled without output backpressure")

	// a good verdict is never for an empty label
	`ULV_ASSERT_NOW(a_ok_nonempty, out_valid && label_ok, label_length != 8'd0, "good verdict with zero length")

	// a stalled verdict holds
	`ULV_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(label_ok) && $stable(label_length), "stalled verdict changed")

	// a stalled result register keeps input stalled until the output is taken
	`ULV_ASSERT_NEXT(a_stall_keeps, !in_ready && !out_ready, !in_ready || out_ready, "input released while output still stalled")

endmodule

bind utf8_label_validator ulv_checker u_ulv_checker (.*);

`default_nettype wire

// File: sim/utf8_label_validator_tb.sv
// testbench of the utf8 label validator: random and directed label streams, checked per verdict
// depends on ulv_pkg and utf8_label_validator

module utf8_label_validator_tb;
	import ulv_pkg::*;

	// traffic phases: who idles, and how often
	localparam int PH_SLOW_RECV = 0;
	localparam int PH_SLOW_SEND = 1;
	localparam int PH_STEADY    = 2;

	localparam int STREAM_BYTES  = 1250;
	localparam int HOLD_CYCLES   = 200;
	localparam int DRAIN_CYCLES  = 20;
	localparam int WATCHDOG_SPAN = 2000;

	// hand-picked opening labels: zero length, byte extremes, every error kind, largest scalar
	localparam bit [7:0] OPENING [33] = '{
		8'h00,
		8'h02, 8'h00, 8'h7F,
		8'h02, 8'hC2, 8'h80,
		8'h01, 8'hFF,
		8'h02, 8'hE0, 8'hA0,
		8'h03, 8'hE0, 8'h80, 8'h80,
		8'h03, 8'hED, 8'hA0, 8'h80,
		8'h04, 8'hF4, 8'h90, 8'h80, 8'h80,
		8'h04, 8'hF4, 8'h8F, 8'hBF, 8'hBF,
		8'h02, 8'hC3, 8'h41
	};

	// label decoder mirror and store of verdicts still owed by the block
	class label_judge;
		bit [7:0]  bytes_left;
		bit [7:0]  record_length;
		bit [1:0]  cont_due;
		bit [1:0]  seq_class;
		bit [20:0] code_acc;
		bit        broken;
		bit        due_ok[$];
		bit [7:0]  due_len[$];
		int        mismatches;

		function new();
			mismatches = 0;
			forget_label();
		endfunction

		function void forget_label();
			bytes_left    = 8'd0;
			record_length = 8'd0;
			cont_due      = 2'd0;
			seq_class     = CLS_NONE;
			code_acc      = 21'd0;
			broken        = 1'b0;
		endfunction

		// utf8 decode of one label byte while no error has been seen
		function void decode(bit [7:0] b);
			bit [20:0] floor;
			if (cont_due == 2'd0) begin
				if (b < ASCII_LIMIT)
					return;
				if (b >= LEAD2_LO && b <= LEAD2_HI) begin
					cont_due  = 2'd1;
					seq_class = CLS_TWO;
					code_acc  = {16'd0, b[4:0]};
				end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
					cont_due  = 2'd2;
					seq_class = CLS_THREE;
					code_acc  = {17'd0, b[3:0]};
				end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
					cont_due  = 2'd3;
					seq_class = CLS_FOUR;
					code_acc  = {18'd0, b[2:0]};
				end else begin
					broken = 1'b1;
					return;
				end
				// sequence cut off by the end of the label
				if (bytes_left < cont_due)
					broken = 1'b1;
				return;
			end
			if (b[7:6] != CONT_TAG) begin
				broken = 1'b1;
				return;
			end
			code_acc = {code_acc[14:0], b[5:0]};
			cont_due = cont_due - 2'd1;
			// complete sequence: overlong, surrogate and range checks
			if (cont_due == 2'd0) begin
				case (seq_class)
					CLS_TWO:   floor = MIN_TWO;
					CLS_THREE: floor = MIN_THREE;
					default:   floor = MIN_FOUR;
				endcase
				if (code_acc < floor || code_acc > CODE_MAX ||
				    (code_acc >= SURR_LO && code_acc <= SURR_HI))
					broken = 1'b1;
			end
		endfunction

		// one accepted input beat
		function void take_byte(bit [7:0] b);
			if (bytes_left == 8'd0) begin
				if (b == 8'd0) begin
					due_ok.push_back(1'b0);
					due_len.push_back(8'd0);
					return;
				end
				forget_label();
				bytes_left    = b;
				record_length = b;
				return;
			end
			bytes_left = bytes_left - 8'd1;
			if (!broken)
				decode(b);
			if (broken)
				cont_due = 2'd0;
			if (bytes_left == 8'd0) begin
				due_ok.push_back(!broken && cont_due == 2'd0);
				due_len.push_back(record_length);
				forget_label();
			end
		endfunction

		// one accepted output beat against the oldest owed verdict
		function void match_verdict(logic ok, logic [7:0] len);
			bit       e_ok;
			bit [7:0] e_len;
			if (due_ok.size() == 0) begin
				$display("%0t: unexpected verdict label_ok=%0b label_length=%0d",
					$time, ok, len);
				mismatches++;
				return;
			end
			e_ok  = due_ok.pop_front();
			e_len = due_len.pop_front();
			if (ok !== e_ok) begin
				$display("%0t: label_ok expected %0b actual %0b", $time, e_ok, ok);
				mismatches++;
			end
			if (len !== e_len) begin
				$display("%0t: label_length expected %0d actual %0d", $time, e_len, len);
				mismatches++;
			end
		endfunction

		function int pending();
			return due_ok.size();
		endfunction
	endclass

	logic       clk = 1'b0;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [7:0] data_byte;
	logic       out_valid;
	logic       out_ready;
	logic       label_ok;
	logic [7:0] label_length;

	label_judge judge;
	bit [7:0]   stream_q[$];
	bit [7:0]   word_q[$];
	int         stream_total;
	int         sent_count;
	int         phase;
	int         hold_left;
	bit         pressure_done;
	int         quiet_cycles;

	utf8_label_validator DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.data_byte    (data_byte),
		.out_valid    (out_valid),
		.out_ready    (out_ready),
		.label_ok     (label_ok),
		.label_length (label_length)
	);

	// clock
	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// utf8 encoding of a code point in n bytes, overlong or out of range if asked
	task automatic put_code(bit [20:0] cp, int n);
		case (n)
			1: word_q.push_back({1'b0, cp[6:0]});
			2: begin
				word_q.push_back({3'b110, cp[10:6]});
				word_q.push_back({2'b10, cp[5:0]});
			end
			3: begin
				word_q.push_back({4'b1110, cp[15:12]});
				word_q.push_back({2'b10, cp[11:6]});
				word_q.push_back({2'b10, cp[5:0]});
			end
			default: begin
				word_q.push_back({5'b11110, cp[20:18]});
				word_q.push_back({2'b10, cp[17:12]});
				word_q.push_back({2'b10, cp[11:6]});
				word_q.push_back({2'b10, cp[5:0]});
			end
		endcase
	endtask

	// one symbol: mostly well-formed, some overlong, surrogate, out of range, noise or with a damaged continuation
	task automatic append_symbol();
		int        pick;
		bit [20:0] cp;
		pick = $urandom_range(99);
		if (pick < 35) begin
			put_code($urandom_range(8'h7F), 1);
		end else if (pick < 55) begin
			put_code($urandom_range(12'h7FF, 8'h80), 2);
		end else if (pick < 70) begin
			cp = $urandom_range(16'hFFFF, 12'h800);
			if (cp >= SURR_LO && cp <= SURR_HI)
				cp = cp + 21'h800;
			put_code(cp, 3);
		end else if (pick < 80) begin
			put_code($urandom_range(21'h10FFFF, 21'h10000), 4);
		end else if (pick < 85) begin
			// mostly overlong: a value of up to 16 bits, shifted down, in two to four bytes
			cp = $urandom_range(16'hFFFF);
			put_code(cp >> ($urandom_range(2) * 5), $urandom_range(4, 2));
		end else if (pick < 88) begin
			put_code($urandom_range(SURR_HI, SURR_LO), 3);
		end else if (pick < 91) begin
			put_code(21'h110000 + $urandom_range(21'h2FFFF), 4);
		end else if (pick < 96) begin
			word_q.push_back($urandom_range(255));
		end else begin
			// well-formed lead with a damaged continuation
			put_code($urandom_range(16'hFFFF, 12'h800), 3);
			word_q[word_q.size() - 1 - $urandom_range(1)] = $urandom_range(255);
		end
	endtask

	// length byte then the label, the last symbol cut off where it overruns
	task automatic build_label(int len);
		int i;
		word_q.delete();
		while (word_q.size() < len)
			append_symbol();
		stream_q.push_back(len);
		for (i = 0; i < len; i++)
			stream_q.push_back(word_q[i]);
	endtask

	task automatic build_stream();
		int roll;
		foreach (OPENING[i])
			stream_q.push_back(OPENING[i]);
		build_label(255);
		while (stream_q.size() < STREAM_BYTES) begin
			roll = $urandom_range(99);
			if (roll < 4)
				build_label(0);
			else if (roll < 75)
				build_label($urandom_range(8, 1));
			else if (roll < 97)
				build_label($urandom_range(40, 9));
			else
				build_label($urandom_range(254, 41));
		end
	endtask

	function automatic int send_gap_pct();
		return (phase == PH_SLOW_RECV) ? 38 : (phase == PH_SLOW_SEND) ? 65 : 0;
	endfunction

	function automatic int stall_pct();
		return (phase == PH_SLOW_RECV) ? 65 : (phase == PH_SLOW_SEND) ? 38 : 0;
	endfunction

	// sender: offer the next beat and hold it until taken
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				judge.take_byte(data_byte);
				sent_count <= sent_count + 1;
				if (sent_count + 1 >= 2 * stream_total / 3)
					phase <= PH_STEADY;
				else if (sent_count + 1 >= stream_total / 3)
					phase <= PH_SLOW_SEND;
			end
			if (!in_valid || in_ready) begin
				if (stream_q.size() != 0 && $urandom_range(99) >= send_gap_pct()) begin
					in_valid  <= 1'b1;
					data_byte <= stream_q.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: check each verdict beat, stall at random, one long hold-off
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && out_ready)
				judge.match_verdict(label_ok, label_length);
			if (hold_left != 0) begin
				out_ready <= 1'b0;
				hold_left <= hold_left - 1;
			end else if (phase == PH_STEADY && !pressure_done) begin
				out_ready     <= 1'b0;
				hold_left     <= HOLD_CYCLES;
				pressure_done <= 1'b1;
			end else begin
				out_ready <= ($urandom_range(99) >= stall_pct());
			end
		end
	end

	// watchdog: too long without a beat on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles + 1 >= WATCHDOG_SPAN) begin
				$display("tb: failure");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	// reset, stimulus, drain and verdict
	initial begin
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		data_byte     = 8'd0;
		out_ready     = 1'b0;
		sent_count    = 0;
		phase         = PH_SLOW_RECV;
		hold_left     = 0;
		pressure_done = 1'b0;
		quiet_cycles  = 0;
		judge         = new();
		build_stream();
		stream_total  = stream_q.size();
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		while (stream_q.size() != 0 || in_valid)
			@(posedge clk);
		while (judge.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (judge.mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
